[rtl/skvt_pkg.sv]
package skvt_pkg;

  localparam int CAPACITY   = 16;
  localparam int KEY_BITS   = 16;
  localparam int VALUE_BITS = 16;

  // port field widths
  localparam int MODE_W   = 2;
  localparam int KEY_W    = 16;
  localparam int VALUE_W  = 16;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  localparam int IDX_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_BITS = $clog2(CAPACITY + 1);

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [VALUE_BITS-1:0] val_t;
  typedef logic [IDX_BITS-1:0]   idx_t;
  typedef logic [CNT_BITS-1:0]   cnt_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT  = 2'd0,
    MODE_REM_KEY = 2'd1,
    MODE_REM_VAL = 2'd2,
    MODE_LOOKUP  = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef struct packed {
    logic load;
    logic ins_step;
    logic scan_step;
    logic result;
  } dp_cmd_t;

  typedef struct packed {
    logic ins_done;
    logic scan_done;
    logic out_free;
  } dp_stat_t;

endpackage

[rtl/skvt_req_if.sv]
interface skvt_req_if;
  import skvt_pkg::*;

  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [KEY_W-1:0]   key_in;
  logic [VALUE_W-1:0] value_in;

  modport source (output valid, output mode, output key_in, output value_in, input ready);
  modport sink (input valid, input mode, input key_in, input value_in, output ready);
endinterface

[rtl/skvt_rsp_if.sv]
interface skvt_rsp_if;
  import skvt_pkg::*;

  logic                valid;
  logic                ready;
  logic                hit;
  logic [VALUE_W-1:0]  value_out;
  logic [COUNT_W-1:0]  removed_count;
  logic [COUNT_W-1:0]  entry_count;
  logic [STATUS_W-1:0] status;

  modport source (
    output valid, output hit, output value_out, output removed_count,
    output entry_count, output status, input ready
  );
  modport sink (
    input valid, input hit, input value_out, input removed_count,
    input entry_count, input status, output ready
  );
endinterface

[rtl/sorted_key_value_table.sv]
// channel  dir  fields
// req      in   mode, key_in, value_in
// rsp      out  hit, value_out, removed_count, entry_count, status
//
// One request at a time. Insert walks down from the top of the table, one entry a
// cycle; the removals and lookup walk up over every held entry, one a cycle. The
// next request can transfer once the result is in the output register. A finished
// result sits in an output register; a stalled rsp holds only the final step,
// while the next request may already be taken. Reset empties the table.
module sorted_key_value_table (
  input logic        clk,
  input logic        rst,
  skvt_req_if.sink   req,
  skvt_rsp_if.source rsp
);
  import skvt_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  skvt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_mode  (req.mode),
    .req_ready (req.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  skvt_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .req_mode  (req.mode),
    .req_key   (req.key_in),
    .req_value (req.value_in),
    .rsp       (rsp)
  );

endmodule

[rtl/skvt_ctrl.sv]
module skvt_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  input  logic [skvt_pkg::MODE_W-1:0] req_mode,
  output logic                        req_ready,
  output skvt_pkg::dp_cmd_t           cmd,
  input  skvt_pkg::dp_stat_t          stat
);
  import skvt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_INS  = 4'b0010,
    S_SCAN = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    cmd           = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = (mode_t'(req_mode) == MODE_INSERT) ? S_INS : S_SCAN;
        end
      end
      S_INS: begin
        cmd.ins_step = 1'b1;
        if (stat.ins_done) state_next = S_FIN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) state_next = S_FIN;
      end
      S_FIN: begin
        // wait for the output register to drain
        if (stat.out_free) begin
          cmd.result = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/skvt_datapath.sv]
module skvt_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  skvt_pkg::dp_cmd_t            cmd,
  output skvt_pkg::dp_stat_t           stat,
  input  logic [skvt_pkg::MODE_W-1:0]  req_mode,
  input  logic [skvt_pkg::KEY_W-1:0]   req_key,
  input  logic [skvt_pkg::VALUE_W-1:0] req_value,
  skvt_rsp_if.source                   rsp
);
  import skvt_pkg::*;

  key_t  key_mem [CAPACITY];
  val_t  val_mem [CAPACITY];

  cnt_t  fill, rptr, wptr, removed;
  mode_t op;
  key_t  k;
  val_t  v;
  logic  full, found;
  val_t  vcap;

  logic                out_valid;
  logic                out_hit;
  logic [VALUE_W-1:0]  out_value;
  logic [COUNT_W-1:0]  out_removed;
  logic [COUNT_W-1:0]  out_entries;
  status_t             out_status;

  idx_t ridx, pidx, widx;
  key_t rkey, pkey;
  val_t rval, pval;
  logic ins_done, scan_done, drop, lk_hit, compact;

  always_comb begin
    ridx = rptr[IDX_BITS-1:0];
    pidx = ridx - 1'b1;
    widx = wptr[IDX_BITS-1:0];
    rkey = key_mem[ridx];
    rval = val_mem[ridx];
    pkey = key_mem[pidx];
    pval = val_mem[pidx];
    // insert walks down from the top, moving up every entry whose key is not below the new one
    ins_done  = full || (rptr == '0) || (pkey < k);
    scan_done = (rptr == fill);
    drop      = ((op == MODE_REM_VAL) && (rval == v)) ||
                ((op == MODE_REM_KEY) && !found && (rkey == k));
    lk_hit    = (op == MODE_LOOKUP) && !found && (rkey == k);
    compact   = cmd.scan_step && !scan_done && (op != MODE_LOOKUP) && !drop;
  end

  assign stat.ins_done  = ins_done;
  assign stat.scan_done = scan_done;
  assign stat.out_free  = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (cmd.ins_step) begin
      if (!ins_done) begin
        key_mem[ridx] <= pkey;
        val_mem[ridx] <= pval;
      end else if (!full) begin
        key_mem[ridx] <= k;
        val_mem[ridx] <= v;
      end
    end
    if (compact) begin
      key_mem[widx] <= rkey;
      val_mem[widx] <= rval;
    end
  end

  // request registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op   <= mode_t'(req_mode);
      k    <= key_t'(req_key);
      v    <= val_t'(req_value);
      full <= (fill == cnt_t'(CAPACITY));
    end
    if (cmd.load) begin
      vcap <= '0;
    end else if (cmd.scan_step && !scan_done && lk_hit) begin
      vcap <= rval;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      rptr    <= '0;
      wptr    <= '0;
      removed <= '0;
      found   <= 1'b0;
    end else begin
      if (cmd.load) begin
        rptr    <= (mode_t'(req_mode) == MODE_INSERT) ? fill : '0;
        wptr    <= '0;
        removed <= '0;
        found   <= 1'b0;
      end
      if (cmd.ins_step) begin
        if (!ins_done) begin
          rptr <= rptr - 1'b1;
        end else if (!full) begin
          fill <= fill + 1'b1;
        end
      end
      if (cmd.scan_step) begin
        if (!scan_done) begin
          rptr <= rptr + 1'b1;
          if (drop) begin
            removed <= removed + 1'b1;
            found   <= 1'b1;
          end else if (lk_hit) begin
            found <= 1'b1;
          end
          if (compact) wptr <= wptr + 1'b1;
        end else if (op != MODE_LOOKUP) begin
          fill <= wptr;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.result) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result) begin
      out_hit     <= (op != MODE_INSERT) && found;
      out_value   <= VALUE_W'(vcap);
      out_removed <= COUNT_W'(removed);
      out_entries <= COUNT_W'(fill);
      if (op == MODE_INSERT) begin
        out_status <= full ? ST_FULL : ST_OK;
      end else begin
        out_status <= found ? ST_OK : ST_NOT_FOUND;
      end
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.hit           = out_hit;
  assign rsp.value_out     = out_value;
  assign rsp.removed_count = out_removed;
  assign rsp.entry_count   = out_entries;
  assign rsp.status        = out_status;

endmodule
